/* hdl/bounded_combination_enumerator_core_defines.svh */
// ----------------------------------------------------------------------------
// bounded_combination_enumerator_core_defines
// Assertion macros used by the checker file.
// ----------------------------------------------------------------------------
`ifndef BOUNDED_COMBINATION_ENUMERATOR_CORE_DEFINES_SVH
`define BOUNDED_COMBINATION_ENUMERATOR_CORE_DEFINES_SVH
// Implication checked on every clock edge outside reset.
`define BCE_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication checked outside reset.
`define BCE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

/* hdl/bce_pkg.sv */
// ----------------------------------------------------------------------------
// bce_pkg
// Shared constants and types of the combination enumerator.
// ----------------------------------------------------------------------------
package bce_pkg;
	localparam int STR_W    = 32;
	localparam int CNT_W    = 6;
	localparam int ENERGY_W = 37;
	localparam int IDX_W    = 5;
	localparam int WVAL_W   = 32;

	localparam logic [1:0] MODE_LOAD   = 2'd0;
	localparam logic [1:0] MODE_START  = 2'd1;
	localparam logic [1:0] MODE_STEP   = 2'd2;
	// This mode is accepted and dropped.
	localparam logic [1:0] MODE_UNUSED = 2'd3;

	localparam logic [1:0] REG_THRESHOLD = 2'd0;
	localparam logic [1:0] REG_LENGTH    = 2'd1;
	localparam logic [1:0] REG_ONES      = 2'd2;
	localparam logic [1:0] REG_OCCUPIED  = 2'd3;

	// Command handed from the front end to the back end.
	typedef struct packed {
		logic [1:0]        mode;
		logic [IDX_W-1:0]  weight_index;
		logic [WVAL_W-1:0] weight_value;
	} cmd_t;
endpackage

/* hdl/bce_if.sv */
// ----------------------------------------------------------------------------
// bce_in_if / bce_out_if / bce_cfg_if
// Valid/ready channels of the combination enumerator.
// ----------------------------------------------------------------------------
interface bce_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  mode;
	logic [4:0]  weight_index;
	logic [31:0] weight_value;
	modport source (output valid, mode, weight_index, weight_value, input ready);
	modport sink (input valid, mode, weight_index, weight_value, output ready);
endinterface

interface bce_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] string_bits;
	logic [36:0] energy;
	logic        accepted;
	logic        last;
	modport source (output valid, string_bits, energy, accepted, last, input ready);
	modport sink (input valid, string_bits, energy, accepted, last, output ready);
endinterface

interface bce_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  index;
	logic [36:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

/* hdl/bce_front.sv */
// ----------------------------------------------------------------------------
// bce_front
// Accepts items, drops unused modes and queues commands for the back end.
// ----------------------------------------------------------------------------
module bce_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  bce_pkg::cmd_t     in_cmd,
	output logic              q_valid,
	input  logic              q_ready,
	output bce_pkg::cmd_t     q_cmd
);
	bce_pkg::cmd_t mem_q [2];
	logic          wr_q, rd_q;
	logic [1:0]    cnt_q;
	logic          push, pop;

	assign in_ready = (cnt_q != 2'd2);
	assign push     = in_valid && in_ready && (in_cmd.mode != bce_pkg::MODE_UNUSED);
	assign q_valid  = (cnt_q != 2'd0);
	assign pop      = q_valid && q_ready;
	assign q_cmd    = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= in_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (pop) rd_q <= ~rd_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end
endmodule

/* hdl/bce_back.sv */
// ----------------------------------------------------------------------------
// bce_back
// Weight table, string state and the sequential advance search.
// ----------------------------------------------------------------------------
module bce_back #(
	parameter int MAX_LENGTH  = 32,
	parameter int WEIGHT_BITS = 32
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              q_valid,
	output logic                              q_ready,
	input  bce_pkg::cmd_t                     q_cmd,
	input  logic signed [bce_pkg::ENERGY_W-1:0] threshold,
	input  logic [bce_pkg::CNT_W-1:0]         string_length,
	input  logic [bce_pkg::CNT_W-1:0]         num_ones,
	input  logic                              occupied_mode,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [bce_pkg::STR_W-1:0]         string_bits,
	output logic signed [bce_pkg::ENERGY_W-1:0] energy,
	output logic                              accepted,
	output logic                              last
);
	localparam int CAP = (MAX_LENGTH < 32) ? MAX_LENGTH : 32;
	localparam int EW  = bce_pkg::ENERGY_W;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_SUM   = 3'd1;
	localparam logic [2:0] ST_SCAN  = 3'd2;
	localparam logic [2:0] ST_CHK   = 3'd3;
	localparam logic [2:0] ST_EXT   = 3'd4;
	localparam logic [2:0] ST_EMIT  = 3'd5;

	logic signed [WEIGHT_BITS-1:0] wtab_q [32];
	logic [31:0] cur_q, work_q, emit_bits;
	logic        finished_q;
	logic [5:0]  len_q;
	logic [2:0]  st_q;
	logic [5:0]  p_q, i_q, held_q, last_q, ext_q;
	logic signed [EW-1:0] acc_q, e_q;
	logic        more_q;
	logic        out_v_q;
	logic signed [EW-1:0] wcur;

	logic [5:0] n_start, k_start;
	always_comb begin
		n_start = (string_length > 6'(CAP)) ? 6'(CAP) : string_length;
		k_start = (num_ones > n_start) ? n_start : num_ones;
	end

	assign wcur = EW'(wtab_q[p_q[4:0]]);
	assign q_ready = (st_q == ST_IDLE) && !out_v_q;
	assign out_valid = out_v_q;

	// Weight table write on each accepted load command.
	always_ff @(posedge clk) begin
		if (q_valid && q_ready && q_cmd.mode == bce_pkg::MODE_LOAD)
			wtab_q[q_cmd.weight_index] <= WEIGHT_BITS'($signed(q_cmd.weight_value));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q       <= ST_IDLE;
			cur_q      <= '0;
			finished_q <= 1'b1;
			len_q      <= '0;
			out_v_q    <= 1'b0;
		end else begin
			if (out_v_q && out_ready) out_v_q <= 1'b0;
			case (st_q)
			ST_IDLE: begin
				if (q_valid && q_ready) begin
					if (q_cmd.mode == bce_pkg::MODE_START) begin
						len_q      <= n_start;
						cur_q      <= (k_start == 6'd0) ? 32'd0 :
						              32'((33'd1 << k_start) - 33'd1);
						finished_q <= 1'b0;
					end else if (q_cmd.mode == bce_pkg::MODE_STEP && !finished_q) begin
						st_q  <= ST_SUM;
						p_q   <= '0;
						acc_q <= '0;
					end
				end
			end
			ST_SUM: begin
				// energy of current string
				if (p_q == len_q) begin
					e_q    <= acc_q;
					work_q <= cur_q;
					held_q <= '0;
					more_q <= 1'b0;
					if (len_q < 6'd2) st_q <= ST_EMIT;
					else begin
						i_q  <= len_q - 6'd1;
						st_q <= ST_SCAN;
					end
				end else begin
					if (cur_q[p_q[4:0]]) acc_q <= acc_q + wcur;
					p_q <= p_q + 6'd1;
				end
			end
			ST_SCAN: begin
				// i_q holds j; test positions j-1 and j
				if (work_q[i_q[4:0]-5'd1] && !work_q[i_q[4:0]]) begin
					work_q[i_q[4:0]-5'd1] <= 1'b0;
					work_q[i_q[4:0]]      <= 1'b1;
					p_q    <= '0;
					acc_q  <= '0;
					last_q <= '0;
					st_q   <= ST_CHK;
				end else if (work_q[i_q[4:0]]) begin
					held_q <= held_q + 6'd1;
					work_q[i_q[4:0]] <= 1'b0;
					if (i_q == 6'd1) st_q <= ST_EMIT;
					else i_q <= i_q - 6'd1;
				end else begin
					if (i_q == 6'd1) st_q <= ST_EMIT;
					else i_q <= i_q - 6'd1;
				end
			end
			ST_CHK: begin
				if (p_q == len_q) begin
					p_q   <= last_q + 6'd1;
					ext_q <= '0;
					st_q  <= ST_EXT;
				end else begin
					if (work_q[p_q[4:0]]) begin
						acc_q  <= acc_q + wcur;
						last_q <= p_q;
					end
					p_q <= p_q + 6'd1;
				end
			end
			ST_EXT: begin
				if (ext_q < held_q && p_q < len_q) begin
					acc_q <= acc_q + wcur;
					p_q   <= p_q + 6'd1;
					ext_q <= ext_q + 6'd1;
				end else if (acc_q < threshold) begin
					// fill held ones right after j
					for (int b = 0; b < 32; b++)
						if (b > int'(i_q) && b <= int'(i_q) + int'(held_q) &&
						    b < int'(len_q))
							work_q[b] <= 1'b1;
					more_q <= 1'b1;
					st_q   <= ST_EMIT;
				end else begin
					held_q <= held_q + 6'd1;
					work_q[i_q[4:0]] <= 1'b0;
					if (i_q == 6'd1) st_q <= ST_EMIT;
					else begin
						i_q  <= i_q - 6'd1;
						st_q <= ST_SCAN;
					end
				end
			end
			ST_EMIT: begin
				if (!out_v_q) begin
					cur_q       <= work_q;
					finished_q  <= !more_q;
					string_bits <= emit_bits;
					energy      <= e_q;
					accepted    <= (e_q < threshold);
					last        <= !more_q;
					out_v_q     <= 1'b1;
					st_q        <= ST_IDLE;
				end
			end
			default: st_q <= ST_IDLE;
			endcase
		end
	end

	// Output view of the current string, reversed and inverted in occupied mode.
	always_comb begin
		emit_bits = cur_q;
		if (occupied_mode) begin
			emit_bits = '0;
			for (int b = 0; b < 32; b++)
				if (b < int'(len_q))
					emit_bits[b] = !cur_q[5'(int'(len_q) - 1 - b)];
		end
	end
endmodule

/* hdl/bounded_combination_enumerator_core.sv */
// ----------------------------------------------------------------------------
// bounded_combination_enumerator_core
// Bounded k-of-n combination enumerator with weight pruning.
// ----------------------------------------------------------------------------
// Items of mode 0 load a weight, mode 1 starts a run and mode 2 emits the
// current combination with its energy and advances; mode 3 is dropped. A step
// takes one sum pass over n positions plus, per candidate move, one pass over
// n positions and a completion pass over the held ones, all through the single
// shared accumulator in the back end. A two-entry queue lets the front accept
// the next item while the back end works, and a finished result waits in the
// output register. Configuration is written while idle by the user; the block
// itself does not enforce it.
module bounded_combination_enumerator_core #(
	parameter int MAX_LENGTH  = 32,
	parameter int WEIGHT_BITS = 32
) (
	input logic clk,
	input logic arst_n,
	bce_in_if.sink   in_ch,
	bce_out_if.source out_ch,
	bce_cfg_if.sink  cfg
);
	logic signed [36:0] threshold_q;
	logic [5:0]         length_q, ones_q;
	logic               occ_q;
	bce_pkg::cmd_t      in_cmd, q_cmd;
	logic               q_valid, q_ready;

	// Configuration transfers are always taken.
	assign cfg.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= '0;
			length_q    <= 6'd32;
			ones_q      <= 6'd1;
			occ_q       <= 1'b0;
		end else if (cfg.valid) begin
			case (cfg.index)
			bce_pkg::REG_THRESHOLD: threshold_q <= cfg.data;
			bce_pkg::REG_LENGTH:    length_q    <= cfg.data[5:0];
			bce_pkg::REG_ONES:      ones_q      <= cfg.data[5:0];
			bce_pkg::REG_OCCUPIED:  occ_q       <= cfg.data[0];
			default: ;
			endcase
		end
	end

	assign in_cmd.mode         = in_ch.mode;
	assign in_cmd.weight_index = in_ch.weight_index;
	assign in_cmd.weight_value = in_ch.weight_value;

	bce_front u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_cmd(in_cmd),
		.q_valid(q_valid), .q_ready(q_ready), .q_cmd(q_cmd)
	);

	bce_back #(.MAX_LENGTH(MAX_LENGTH), .WEIGHT_BITS(WEIGHT_BITS)) u_back (
		.clk(clk), .arst_n(arst_n),
		.q_valid(q_valid), .q_ready(q_ready), .q_cmd(q_cmd),
		.threshold(threshold_q), .string_length(length_q), .num_ones(ones_q),
		.occupied_mode(occ_q),
		.out_valid(out_ch.valid), .out_ready(out_ch.ready),
		.string_bits(out_ch.string_bits), .energy(out_ch.energy),
		.accepted(out_ch.accepted), .last(out_ch.last)
	);
endmodule

/* hdl/bce_checker.sv */
// ----------------------------------------------------------------------------
// bce_checker
// Port-level checks of the combination enumerator.
// ----------------------------------------------------------------------------
`include "bounded_combination_enumerator_core_defines.svh"
module bce_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [31:0] string_bits,
	input logic        cfg_ready
);
	`BCE_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(string_bits), "result dropped while stalled")
	`BCE_ASSERT_IMPL(a_cfg_ready, clk, arst_n, 1'b1, cfg_ready, "configuration port not ready")
	`BCE_ASSERT_NEXT(a_one_result, clk, arst_n, out_valid && out_ready, !out_valid, "result repeated")
endmodule

bind bounded_combination_enumerator_core bce_checker u_chk (
	.clk(clk), .arst_n(arst_n), .out_valid(out_ch.valid), .out_ready(out_ch.ready),
	.string_bits(out_ch.string_bits), .cfg_ready(cfg.ready)
);

/* tb/tb_bounded_combination_enumerator_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bounded_combination_enumerator_core
// Self-checking bench for the bounded combination enumerator.
// ----------------------------------------------------------------------------
// A queue of load, start and step items feeds a bursty driver. An in-bench
// predictor tracks the weight table, the current string and the register
// settings, and queues the expected combination for every step transfer while
// a walk is running. A monitor behind a stalling receiver compares each result
// field by field. The run walks through a series of register settings, from
// empty and single position strings up to the full 32 positions, and thresholds
// from the most negative to the most positive value.
module tb_bounded_combination_enumerator_core;
	// Worst step is about n candidate moves, each a sum pass plus completion.
	localparam int STEP_SETTLE = 3000;
	localparam int STALL_LIMIT = 60000;
	localparam int LONG_HOLD   = 400;

	typedef struct {
		logic [1:0]  mode;
		logic [4:0]  idx;
		logic [31:0] val;
		bit          drain;    // wait for every pending result before offering
	} item_t;

	typedef struct {
		logic [31:0] bits;
		logic [36:0] energy;
		logic        accepted;
		logic        is_last;
	} combo_t;

	logic clk;
	logic arst_n;

	bce_in_if  in_ch();
	bce_out_if out_ch();
	bce_cfg_if cfg();

	bounded_combination_enumerator_core uut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch),
		.cfg    (cfg)
	);

	// Pending stimulus and expected combinations.
	item_t  item_q[$];
	combo_t combo_q[$];
	int     error_count;
	int     step_count;
	int     result_count;
	int     last_count;

	// Predictor state: the weight table, the walk and the register copies.
	logic signed [63:0] weight_tbl[32];
	logic [31:0]        walk_bits;
	bit                 walk_done;
	int                 walk_len;
	logic signed [63:0] thr_q;
	int                 len_q;
	int                 ones_q;
	bit                 occ_q;

	// Moves the highest movable one up by a position, as long as the string
	// plus its held ones after its top one stays under the bound. Returns 0 when no
	// further combination exists.
	function automatic bit next_combo(inout logic [31:0] s, input int n,
			input logic signed [63:0] bound);
		int i;
		int j;
		int held;
		int top;
		logic signed [63:0] sum;
		held = 0;
		if (n < 2)
			return 0;
		i = n - 1;
		forever begin
			j = i;
			i = i - 1;
			if (s[i] && !s[j]) begin
				s[i] = 1'b0;
				s[j] = 1'b1;
				sum = 0;
				top = 0;
				for (int p = 0; p < n; p++)
					if (s[p]) begin
						sum += weight_tbl[p];
						top = p;
					end
				for (int p = top + 1; p < top + 1 + held && p < n; p++)
					sum += weight_tbl[p];
				if (sum < bound) begin
					for (int p = j + 1; p < j + 1 + held && p < n; p++)
						s[p] = 1'b1;
					return 1;
				end
			end
			if (s[j]) begin
				held++;
				s[j] = 1'b0;
			end
			if (i == 0)
				return 0;
		end
	endfunction

	// Applies one accepted item to the predictor.
	task automatic predict_item(input item_t it);
		int n;
		int k;
		logic signed [63:0] e;
		combo_t c;
		bit more;
		case (it.mode)
			bce_pkg::MODE_LOAD: weight_tbl[it.idx] = {{32{it.val[31]}}, it.val};
			bce_pkg::MODE_START: begin
				n = (len_q > 32) ? 32 : len_q;
				k = (ones_q > n) ? n : ones_q;
				walk_len = n;
				walk_bits = (k == 0) ? 32'd0 : ((k >= 32) ? '1 : ((32'd1 << k) - 32'd1));
				walk_done = 0;
			end
			bce_pkg::MODE_STEP: begin
				if (!walk_done) begin
					n = walk_len;
					e = 0;
					for (int p = 0; p < n; p++)
						if (walk_bits[p])
							e += weight_tbl[p];
					c.bits = walk_bits;
					if (occ_q) begin
						c.bits = '0;
						for (int p = 0; p < n; p++)
							c.bits[p] = !walk_bits[n-1-p];
					end
					more = next_combo(walk_bits, n, thr_q);
					if (!more)
						walk_done = 1;
					c.energy = e[36:0];
					c.accepted = (e < thr_q);
					c.is_last = !more;
					combo_q.insert(combo_q.size(), c);
				end
			end
			default: ;
		endcase
	endtask

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		error_count++;
		$display("mismatch at %0t: %s got 0x%0h expected 0x%0h", $realtime, what, got, want);
	endtask

	// Clock and reset. All inputs are set to known values before the first edge.
	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.mode = bce_pkg::MODE_LOAD;
		in_ch.weight_index = '0;
		in_ch.weight_value = '0;
		out_ch.ready = 1'b0;
		cfg.valid = 1'b0;
		cfg.index = bce_pkg::REG_THRESHOLD;
		cfg.data = '0;
		forever #10 clk = ~clk;
	end

	// Driver: sends in bursts with random gaps. A drain item is held back
	// until every expected combination has been delivered.
	int     burst_left;
	int     gap_left;
	item_t  cur_item;
	bit     offering;

	always @(posedge clk) begin
		bit nv;
		item_t nxt;
		nv = offering;
		nxt = cur_item;
		if (arst_n) begin
			if (offering && in_ch.ready) begin
				predict_item(cur_item);
				step_count += (cur_item.mode == bce_pkg::MODE_STEP);
				nv = 0;
			end
			if (!nv) begin
				if (gap_left > 0)
					gap_left--;
				else if (item_q.size() != 0 &&
						!(item_q[0].drain && combo_q.size() != 0)) begin
					nxt = item_q.pop_front();
					nv = 1;
					if (burst_left <= 1) begin
						burst_left = $urandom_range(1, 20);
						gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
					end else
						burst_left--;
				end
			end
			offering = nv;
			cur_item = nxt;
			in_ch.valid <= nv;
			in_ch.mode <= nxt.mode;
			in_ch.weight_index <= nxt.idx;
			in_ch.weight_value <= nxt.val;
		end
	end

	// Receiver: its own stall pattern, plus one long hold-off on request.
	int rx_style;
	int hold_req;
	int hold_seen;
	int hold_left;

	always @(posedge clk) begin
		if (arst_n) begin
			if (hold_req != hold_seen) begin
				hold_seen = hold_req;
				hold_left = LONG_HOLD;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ch.ready <= 1'b0;
			end else begin
				case (rx_style)
					0: out_ch.ready <= 1'b1;
					1: out_ch.ready <= 1'($urandom_range(0, 1));
					default: out_ch.ready <= ($urandom_range(0, 4) == 0);
				endcase
			end
		end
	end

	// Monitor: every delivered combination against the oldest expectation.
	always @(posedge clk) begin
		combo_t c;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			result_count++;
			if (combo_q.size() == 0)
				report_mismatch("unexpected result", 64'(out_ch.string_bits), 64'd0);
			else begin
				c = combo_q.pop_front();
				last_count += c.is_last;
				if (out_ch.string_bits !== c.bits)
					report_mismatch("string_bits", 64'(out_ch.string_bits), 64'(c.bits));
				if (out_ch.energy !== c.energy)
					report_mismatch("energy", 64'(out_ch.energy), 64'(c.energy));
				if (out_ch.accepted !== c.accepted)
					report_mismatch("accepted", 64'(out_ch.accepted), 64'(c.accepted));
				if (out_ch.last !== c.is_last)
					report_mismatch("last", 64'(out_ch.last), 64'(c.is_last));
			end
		end
	end

	// Watchdog: too long without any transfer on any channel ends the run.
	int quiet_cycles;

	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
				(cfg.valid && cfg.ready) || !arst_n)
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles > STALL_LIMIT) begin
			$display("watchdog expired with %0d results outstanding", combo_q.size());
			$display("[bounded_combination_enumerator_core] ERROR");
			$finish;
		end
	end

	task automatic add_item(input logic [1:0] mode, input logic [4:0] idx,
			input logic [31:0] val, input bit drain);
		item_t it;
		it.mode = mode;
		it.idx = idx;
		it.val = val;
		it.drain = drain;
		item_q.insert(item_q.size(), it);
	endtask

	task automatic write_reg(input logic [1:0] index, input logic [36:0] data);
		cfg.valid <= 1'b1;
		cfg.index <= index;
		cfg.data <= data;
		do
			@(posedge clk);
		while (!cfg.ready);
		case (index)
			bce_pkg::REG_THRESHOLD: thr_q = {{27{data[36]}}, data};
			bce_pkg::REG_LENGTH: len_q = int'(data[5:0]);
			bce_pkg::REG_ONES: ones_q = int'(data[5:0]);
			bce_pkg::REG_OCCUPIED: occ_q = data[0];
			default: ;
		endcase
		cfg.valid <= 1'b0;
		@(posedge clk);
	endtask

	// Blocks until the block has drained all queued work.
	task automatic wait_idle();
		while (item_q.size() != 0 || offering || combo_q.size() != 0)
			@(posedge clk);
		repeat (STEP_SETTLE) @(posedge clk);
	endtask

	function automatic logic [31:0] rand_weight();
		case ($urandom_range(0, 5))
			0: return $urandom();
			1: return 32'h8000_0000;
			2: return 32'h7fff_ffff;
			default: return $signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
		endcase
	endfunction

	initial begin
		int steps_left;
		int n;
		logic [36:0] thr;
		error_count = 0;
		step_count = 0;
		result_count = 0;
		last_count = 0;
		burst_left = 0;
		gap_left = 0;
		offering = 0;
		rx_style = 0;
		hold_req = 0;
		hold_seen = 0;
		hold_left = 0;
		quiet_cycles = 0;
		walk_done = 1;
		walk_bits = '0;
		walk_len = 0;
		thr_q = 0;
		len_q = 32;
		ones_q = 1;
		occ_q = 0;
		foreach (weight_tbl[p])
			weight_tbl[p] = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part: a step before any start gives nothing, then every
		// weight is loaded, including the most negative and positive values.
		// A start under reset settings then takes six steps with a single one in 32 positions.
		add_item(bce_pkg::MODE_STEP, 5'd0, 32'd0, 1'b0);
		add_item(bce_pkg::MODE_UNUSED, 5'd31, '1, 1'b0);
		for (int p = 0; p < 32; p++)
			add_item(bce_pkg::MODE_LOAD, p[4:0], (p == 0) ? 32'h8000_0000 :
				(p == 31) ? 32'h7fff_ffff : rand_weight(), 1'b0);
		add_item(bce_pkg::MODE_START, 5'd0, 32'd0, 1'b0);
		for (int s = 0; s < 6; s++)
			add_item(bce_pkg::MODE_STEP, 5'd0, 32'd0, 1'b0);
		wait_idle();

		// Each phase picks register settings, restarts the walk and steps
		// it with reloads, stray items and restarts mixed in.
		for (int ph = 0; ph < 24; ph++) begin
			case (ph % 6)
				0: thr = 37'h0f_ffff_ffff;               // most positive
				1: thr = 37'h10_0000_0000;               // most negative
				2: thr = 37'd0;
				default: thr = {5'b0, $urandom()} - 37'h0_8000_0000;
			endcase
			write_reg(bce_pkg::REG_THRESHOLD, thr);
			case (ph)
				3: n = 0;
				4: n = 63;
				5, 11: n = 32;
				7: n = 1;
				default: n = $urandom_range(2, 10);
			endcase
			write_reg(bce_pkg::REG_LENGTH, 37'({$urandom(), n[5:0]}));
			case (ph % 5)
				0: write_reg(bce_pkg::REG_ONES, 37'd0);
				1: write_reg(bce_pkg::REG_ONES, (ph == 11) ? 37'd3 : 37'd40);
				default: write_reg(bce_pkg::REG_ONES,
					37'($urandom_range(1, (n > 1 && n < 33) ? n - 1 : 1)));
			endcase
			write_reg(bce_pkg::REG_OCCUPIED, 37'($urandom_range(0, 1)));
			rx_style = ph % 3;
			if (ph == 9)
				hold_req++;
			add_item(bce_pkg::MODE_START, 5'($urandom()), $urandom(), 1'b0);
			steps_left = (ph == 5 || ph == 11) ? 10 : 26;
			while (steps_left > 0) begin
				case ($urandom_range(0, 19))
					0: add_item(bce_pkg::MODE_LOAD, 5'($urandom()), rand_weight(), 1'b0);
					1: add_item(bce_pkg::MODE_UNUSED, 5'($urandom()), $urandom(), 1'b0);
					2: add_item(bce_pkg::MODE_START, 5'($urandom()), $urandom(), 1'b0);
					3: add_item(bce_pkg::MODE_STEP, 5'($urandom()), $urandom(), 1'b1);
					default: add_item(bce_pkg::MODE_STEP, 5'($urandom()), $urandom(), 1'b0);
				endcase
				steps_left--;
			end
			wait_idle();
		end

		$display("%0d steps sent, %0d combinations checked, %0d walk ends, %0d mismatches",
			step_count, result_count, last_count, error_count);
		$display("settings covered empty to full-length strings, all thresholds, both modes");
		if (error_count == 0)
			$display("[bounded_combination_enumerator_core] OK");
		else
			$display("[bounded_combination_enumerator_core] ERROR");
		$finish;
	end
endmodule
